### sv/software_timer_pool_macros.svh
// ---------------------------------------------------------------------------
// software_timer_pool assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_POOL_MACROS_SVH
`define SOFTWARE_TIMER_POOL_MACROS_SVH

// same-cycle implication, masked during reset
`define STP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stp assertion failed");

// next-cycle implication, masked during reset
`define STP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stp assertion failed");

// next-cycle implication, also checked across reset
`define STP_ASSERT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("stp assertion failed");

`endif

### sv/stp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stp_pkg
// Types and constants shared by the timer pool modules.
// ---------------------------------------------------------------------------
package stp_pkg;

  localparam int TIMERS = 32;
  localparam int SLOT_W = 5;
  localparam int LINK_W = 6;
  localparam int AW     = $clog2(TIMERS);

  localparam logic [LINK_W-1:0] NIL       = LINK_W'(TIMERS);
  localparam logic [31:0]       NONE_DUE  = 32'hFFFF_FFFF;
  localparam logic [31:0]       COUNT_MAX = 32'hFFFF_FFFE;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_ALLOC     = 3'd1;
  localparam logic [2:0] CMD_FREE      = 3'd2;
  localparam logic [2:0] CMD_INIT      = 3'd3;
  localparam logic [2:0] CMD_SETTIME   = 3'd4;
  localparam logic [2:0] CMD_CANCEL    = 3'd5;
  localparam logic [2:0] CMD_CANCELALL = 3'd6;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_ARMED = 2'd2;

  localparam logic [2:0] REG_SWITCH_SLOT = 3'd0;

  typedef struct packed {
    logic [2:0]         command;
    logic [4:0]         slot;
    logic [7:0]         owner;
    logic signed [31:0] tag;
    logic               auto_cancel;
    logic [31:0]        duration;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         out_slot;
    logic [7:0]         out_owner;
    logic signed [31:0] out_tag;
    logic               ok;
    logic               switch_request;
    logic               last;
  } res_t;

endpackage

### sv/software_timer_pool.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// software_timer_pool
// Pool of 32 timer slots with a due-time ordered expiry list.
// ---------------------------------------------------------------------------
// Usage:
//   Commands enter on cmd_valid/cmd_ready, one item at a time; results leave
//   on res_valid/res_ready through a single output register. Every command
//   yields exactly one done item (last = 1); a tick first yields one expiry
//   item per due slot other than switch_slot, in list order.
//   Flow: init, alloc, unknown commands and free or cancel of an unarmed
//   slot go straight to their done item, and the next item is accepted
//   only once that one is loaded; a tick adds a read and a check per expired
//   slot; an unlink walks the list entry by entry, an insert reads each
//   entry it passes, and settime may do both walks; cancel-all scans all
//   slots in turn, reads the owner of each marked slot, and adds an
//   unlink walk for each armed one whose owner matches.
//   The link memory's single read port with registered read data sets this pace.
//   Reset empties the list, frees all slots, clears the counter and sets
//   switch_slot to 32 (none); no clearing pass is needed.
//   When the receiver stalls, the sequencer holds at its next result and
//   the held item stays unchanged on res until it is taken.
//   switch_slot sits at APB address 0.
// ---------------------------------------------------------------------------
module software_timer_pool (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  stp_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output stp_pkg::res_t res
);
  import stp_pkg::*;

  logic [5:0] switch_slot;
  logic       res_load;
  logic       res_free;
  res_t       res_d;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_SWITCH_SLOT) ? {26'd0, switch_slot} : 32'd0;
  assign res_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_slot <= 6'd32;
    end else if (psel && penable && pwrite && paddr == REG_SWITCH_SLOT) begin
      switch_slot <= pwdata[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load && res_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && res_free) begin
      res <= res_d;
    end
  end

  stp_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .switch_slot(switch_slot),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .res_load   (res_load),
    .res_free   (res_free),
    .res_d      (res_d)
  );

endmodule

### sv/stp_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stp_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module stp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/stp_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stp_seq
// Command sequencer: slot status, list memory walks and result generation.
// ---------------------------------------------------------------------------
module stp_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic [5:0]    switch_slot,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  stp_pkg::cmd_t cmd,
  output logic          res_load,
  input  logic          res_free,
  output stp_pkg::res_t res_d
);
  import stp_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TICK_RD  = 4'd1;
  localparam logic [3:0] S_TICK_CHK = 4'd2;
  localparam logic [3:0] S_UNL      = 4'd3;
  localparam logic [3:0] S_UNL_HEAD = 4'd4;
  localparam logic [3:0] S_UNL_WALK = 4'd5;
  localparam logic [3:0] S_UNL_FIX  = 4'd6;
  localparam logic [3:0] S_INS      = 4'd7;
  localparam logic [3:0] S_INS_HEAD = 4'd8;
  localparam logic [3:0] S_INS_STEP = 4'd9;
  localparam logic [3:0] S_INS_CMP  = 4'd10;
  localparam logic [3:0] S_INS_LINK = 4'd11;
  localparam logic [3:0] S_CA       = 4'd12;
  localparam logic [3:0] S_CA_CMP   = 4'd13;
  localparam logic [3:0] S_CA_NEXT  = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  logic [3:0]        state, state_next;
  logic [31:0]       tick_count, tick_count_next;
  logic [LINK_W-1:0] head, head_next;
  logic [1:0]        status [TIMERS];
  logic [1:0]        status_next [TIMERS];
  logic [TIMERS-1:0] ac, ac_next;

  logic [2:0]        cmd_r, cmd_r_next;
  logic [4:0]        slot_r, slot_r_next;
  logic [7:0]        own_r, own_r_next;
  logic [31:0]       due_r, due_r_next;
  logic [LINK_W-1:0] p_r, p_r_next;
  logic [31:0]       pdue_r, pdue_r_next;
  logic [LINK_W-1:0] pn_r, pn_r_next;
  logic [LINK_W-1:0] i_r, i_r_next;
  logic [AW-1:0]     tgt_r, tgt_r_next;
  logic              sw_r, sw_r_next;
  logic              ok_r, ok_r_next;
  logic [4:0]        aslot_r, aslot_r_next;

  logic              l_we, l_re, p_we, p_re;
  logic [AW-1:0]     l_waddr, l_raddr, p_waddr, p_raddr;
  logic [37:0]       l_wdata, l_rdata;
  logic [39:0]       p_wdata, p_rdata;
  logic [31:0]       l_due;
  logic [LINK_W-1:0] l_nxt;
  logic [32:0]       due_sum;
  logic              free_found;
  logic [AW-1:0]     free_idx;
  logic              accept;

  assign l_due     = l_rdata[37:6];
  assign l_nxt     = l_rdata[5:0];
  assign due_sum   = {1'b0, tick_count} + {1'b0, cmd.duration};
  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  stp_ram #(.WIDTH(38), .DEPTH(TIMERS)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  stp_ram #(.WIDTH(40), .DEPTH(TIMERS)) u_data (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = TIMERS - 1; k >= 0; k--) begin
      if (status[k] == ST_FREE) begin
        free_found = 1'b1;
        free_idx   = AW'(k);
      end
    end
  end

  always_comb begin
    state_next      = state;
    tick_count_next = tick_count;
    head_next       = head;
    status_next     = status;
    ac_next         = ac;
    cmd_r_next      = cmd_r;
    slot_r_next     = slot_r;
    own_r_next      = own_r;
    due_r_next      = due_r;
    p_r_next        = p_r;
    pdue_r_next     = pdue_r;
    pn_r_next       = pn_r;
    i_r_next        = i_r;
    tgt_r_next      = tgt_r;
    sw_r_next       = sw_r;
    ok_r_next       = ok_r;
    aslot_r_next    = aslot_r;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0;
    l_re = 1'b0; l_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0;
    p_re = 1'b0; p_raddr = '0;
    res_load = 1'b0;
    res_d    = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_r_next   = cmd.command;
          slot_r_next  = cmd.slot;
          own_r_next   = cmd.owner;
          tgt_r_next   = AW'(cmd.slot);
          due_r_next   = due_sum[32] ? NONE_DUE : due_sum[31:0];
          sw_r_next    = 1'b0;
          ok_r_next    = 1'b0;
          aslot_r_next = '0;
          state_next   = S_DONE;
          unique case (cmd.command)
            CMD_TICK: begin
              if (tick_count < COUNT_MAX) begin
                tick_count_next = tick_count + 32'd1;
              end
              state_next = S_TICK_RD;
            end
            CMD_ALLOC: begin
              if (free_found) begin
                status_next[free_idx] = ST_ALLOC;
                ac_next[free_idx]     = 1'b0;
                aslot_r_next          = 5'(free_idx);
                ok_r_next             = 1'b1;
              end
            end
            CMD_FREE: begin
              if (status[AW'(cmd.slot)] == ST_ARMED) begin
                state_next = S_UNL;
              end
              status_next[AW'(cmd.slot)] = ST_FREE;
            end
            CMD_INIT: begin
              p_we    = 1'b1;
              p_waddr = AW'(cmd.slot);
              p_wdata = {cmd.owner, cmd.tag};
              ac_next[AW'(cmd.slot)] = cmd.auto_cancel;
            end
            CMD_SETTIME: begin
              state_next = (status[AW'(cmd.slot)] == ST_ARMED) ? S_UNL : S_INS;
              status_next[AW'(cmd.slot)] = ST_ARMED;
            end
            CMD_CANCEL: begin
              if (status[AW'(cmd.slot)] == ST_ARMED) begin
                ok_r_next  = 1'b1;
                status_next[AW'(cmd.slot)] = ST_ALLOC;
                state_next = S_UNL;
              end
            end
            CMD_CANCELALL: begin
              i_r_next   = '0;
              state_next = S_CA;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      S_TICK_RD: begin
        if (head == NIL) begin
          state_next = S_DONE;
        end else begin
          l_re       = 1'b1;
          l_raddr    = head[AW-1:0];
          p_re       = 1'b1;
          p_raddr    = head[AW-1:0];
          state_next = S_TICK_CHK;
        end
      end

      S_TICK_CHK: begin
        if (l_due > tick_count) begin
          state_next = S_DONE;
        end else if (head == switch_slot) begin
          sw_r_next = 1'b1;
          status_next[head[AW-1:0]] = ST_ALLOC;
          head_next  = l_nxt;
          state_next = S_TICK_RD;
        end else begin
          res_load           = 1'b1;
          res_d.kind         = 1'b1;
          res_d.out_slot     = 5'(head[AW-1:0]);
          res_d.out_owner    = p_rdata[39:32];
          res_d.out_tag      = p_rdata[31:0];
          if (res_free) begin
            status_next[head[AW-1:0]] = ST_ALLOC;
            head_next  = l_nxt;
            state_next = S_TICK_RD;
          end
        end
      end

      S_UNL: begin
        if (head == LINK_W'(tgt_r)) begin
          l_re       = 1'b1;
          l_raddr    = tgt_r;
          state_next = S_UNL_HEAD;
        end else begin
          l_re       = 1'b1;
          l_raddr    = head[AW-1:0];
          p_r_next   = head;
          state_next = S_UNL_WALK;
        end
      end

      S_UNL_HEAD: begin
        head_next = l_nxt;
        priority case (cmd_r)
          CMD_SETTIME:   state_next = S_INS;
          CMD_CANCELALL: state_next = S_CA_NEXT;
          default:       state_next = S_DONE;
        endcase
      end

      S_UNL_WALK: begin
        if (l_nxt == LINK_W'(tgt_r)) begin
          pdue_r_next = l_due;
          l_re        = 1'b1;
          l_raddr     = tgt_r;
          state_next  = S_UNL_FIX;
        end else if (l_nxt == NIL) begin
          priority case (cmd_r)
            CMD_SETTIME:   state_next = S_INS;
            CMD_CANCELALL: state_next = S_CA_NEXT;
            default:       state_next = S_DONE;
          endcase
        end else begin
          p_r_next = l_nxt;
          l_re     = 1'b1;
          l_raddr  = l_nxt[AW-1:0];
        end
      end

      S_UNL_FIX: begin
        l_we    = 1'b1;
        l_waddr = p_r[AW-1:0];
        l_wdata = {pdue_r, l_nxt};
        priority case (cmd_r)
          CMD_SETTIME:   state_next = S_INS;
          CMD_CANCELALL: state_next = S_CA_NEXT;
          default:       state_next = S_DONE;
        endcase
      end

      S_INS: begin
        if (head == NIL) begin
          l_we       = 1'b1;
          l_waddr    = AW'(slot_r);
          l_wdata    = {due_r, NIL};
          head_next  = LINK_W'(slot_r);
          state_next = S_DONE;
        end else begin
          l_re       = 1'b1;
          l_raddr    = head[AW-1:0];
          state_next = S_INS_HEAD;
        end
      end

      S_INS_HEAD: begin
        if (due_r <= l_due) begin
          l_we       = 1'b1;
          l_waddr    = AW'(slot_r);
          l_wdata    = {due_r, head};
          head_next  = LINK_W'(slot_r);
          state_next = S_DONE;
        end else begin
          p_r_next    = head;
          pdue_r_next = l_due;
          pn_r_next   = l_nxt;
          state_next  = S_INS_STEP;
        end
      end

      S_INS_STEP: begin
        if (pn_r == NIL) begin
          l_we       = 1'b1;
          l_waddr    = AW'(slot_r);
          l_wdata    = {due_r, NIL};
          state_next = S_INS_LINK;
        end else begin
          l_re       = 1'b1;
          l_raddr    = pn_r[AW-1:0];
          state_next = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        if (due_r <= l_due) begin
          l_we       = 1'b1;
          l_waddr    = AW'(slot_r);
          l_wdata    = {due_r, pn_r};
          state_next = S_INS_LINK;
        end else begin
          p_r_next    = pn_r;
          pdue_r_next = l_due;
          pn_r_next   = l_nxt;
          state_next  = S_INS_STEP;
        end
      end

      S_INS_LINK: begin
        l_we       = 1'b1;
        l_waddr    = p_r[AW-1:0];
        l_wdata    = {pdue_r, LINK_W'(slot_r)};
        state_next = S_DONE;
      end

      S_CA: begin
        if (i_r == LINK_W'(TIMERS)) begin
          state_next = S_DONE;
        end else if (status[i_r[AW-1:0]] != ST_FREE && ac[i_r[AW-1:0]]) begin
          p_re       = 1'b1;
          p_raddr    = i_r[AW-1:0];
          state_next = S_CA_CMP;
        end else begin
          i_r_next = i_r + LINK_W'(1);
        end
      end

      S_CA_CMP: begin
        if (p_rdata[39:32] == own_r) begin
          status_next[i_r[AW-1:0]] = ST_FREE;
          if (status[i_r[AW-1:0]] == ST_ARMED) begin
            tgt_r_next = i_r[AW-1:0];
            state_next = S_UNL;
          end else begin
            state_next = S_CA_NEXT;
          end
        end else begin
          state_next = S_CA_NEXT;
        end
      end

      S_CA_NEXT: begin
        i_r_next   = i_r + LINK_W'(1);
        state_next = S_CA;
      end

      S_DONE: begin
        res_load             = 1'b1;
        res_d.out_slot       = aslot_r;
        res_d.ok             = ok_r;
        res_d.switch_request = sw_r;
        res_d.last           = 1'b1;
        if (res_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      head       <= NIL;
      ac         <= '0;
      for (int k = 0; k < TIMERS; k++) begin
        status[k] <= ST_FREE;
      end
    end else begin
      state      <= state_next;
      tick_count <= tick_count_next;
      head       <= head_next;
      ac         <= ac_next;
      status     <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_r_next;
    slot_r  <= slot_r_next;
    own_r   <= own_r_next;
    due_r   <= due_r_next;
    p_r     <= p_r_next;
    pdue_r  <= pdue_r_next;
    pn_r    <= pn_r_next;
    i_r     <= i_r_next;
    tgt_r   <= tgt_r_next;
    sw_r    <= sw_r_next;
    ok_r    <= ok_r_next;
    aslot_r <= aslot_r_next;
  end

endmodule

### sv/stp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stp_checker
// Port-level checks on the result channel of the timer pool.
// ---------------------------------------------------------------------------
`include "software_timer_pool_macros.svh"

module stp_checker (
  input logic          clk,
  input logic          rst,
  input logic          res_valid,
  input logic          res_ready,
  input stp_pkg::res_t res
);
  import stp_pkg::*;

  `STP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
  `STP_ASSERT_NOW(a_last_on_done, res_valid, res.last == !res.kind)
  `STP_ASSERT_NOW(a_expiry_flags, res_valid && res.kind, !res.ok && !res.switch_request)
  `STP_ASSERT_ALWAYS(a_reset_empty, rst, !res_valid)

endmodule

bind software_timer_pool stp_checker u_stp_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res      (res)
);

### verif/software_timer_pool_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// software_timer_pool_tb
// Drives alloc, free, init, settime, cancel, cancel-all, tick and undefined items into
// the timer pool and checks every result against a behavioural model of the
// slot pool and its due-time ordered list, under random idling on both sides.
// ---------------------------------------------------------------------------
module software_timer_pool_tb;
  import stp_pkg::*;

  localparam logic [2:0] CMD_UNDEF = 3'd7;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        cmd_valid;
  logic        cmd_ready;
  cmd_t        cmd;
  logic        res_valid;
  logic        res_ready;
  res_t        res;

  software_timer_pool u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // pool model
  logic [31:0] m_count;
  logic [31:0] m_next_due;
  logic [5:0]  m_head;
  logic [1:0]  m_status [TIMERS];
  logic [31:0] m_due [TIMERS];
  logic [5:0]  m_link [TIMERS];
  logic [7:0]  m_owner [TIMERS];
  logic [31:0] m_tag [TIMERS];
  logic        m_ac [TIMERS];
  logic        m_inited [TIMERS];
  logic [5:0]  m_switch;

  res_t pending_results [$];
  int   errors;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic recv_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void refresh_due();
    m_next_due = (m_head < TIMERS) ? m_due[m_head] : NONE_DUE;
  endfunction

  function automatic void unlink(int s);
    int p;
    if (m_head == s) begin
      m_head = m_link[s];
      refresh_due();
      return;
    end
    p = m_head;
    for (int g = 0; g < TIMERS && p < TIMERS; g++) begin
      if (m_link[p] == s) begin
        m_link[p] = m_link[s];
        return;
      end
      p = m_link[p];
    end
  endfunction

  function automatic void link_in(int s);
    int p;
    int n;
    if (m_head >= TIMERS || m_due[s] <= m_due[m_head]) begin
      m_link[s] = (m_head < TIMERS) ? m_head : NIL;
      m_head = 6'(s);
      refresh_due();
      return;
    end
    p = m_head;
    for (int g = 0; g < TIMERS; g++) begin
      n = m_link[p];
      if (n >= TIMERS || m_due[s] <= m_due[n]) begin
        m_link[s] = (n < TIMERS) ? 6'(n) : NIL;
        m_link[p] = 6'(s);
        return;
      end
      p = n;
    end
  endfunction

  function automatic logic disarm(int s);
    if (m_status[s] != ST_ARMED) return 1'b0;
    unlink(s);
    m_status[s] = ST_ALLOC;
    return 1'b1;
  endfunction

  function automatic void pool_reset();
    m_count = '0;
    m_next_due = NONE_DUE;
    m_head = NIL;
    for (int i = 0; i < TIMERS; i++) begin
      m_status[i] = ST_FREE;
      m_due[i] = '0;
      m_link[i] = '0;
      m_owner[i] = '0;
      m_tag[i] = '0;
      m_ac[i] = 1'b0;
      m_inited[i] = 1'b0;
    end
    m_switch = 6'd32;
  endfunction

  function automatic void predict_pool(cmd_t c);
    res_t  r;
    logic  sw;
    int    h;
    logic [31:0] d;
    r = '0;
    r.last = 1'b1;
    case (c.command)
      CMD_TICK: begin
        sw = 1'b0;
        if (m_count < COUNT_MAX) m_count++;
        if (m_next_due <= m_count) begin
          for (int g = 0; g < TIMERS && m_head < TIMERS; g++) begin
            res_t e;
            h = m_head;
            if (m_due[h] > m_count) break;
            m_status[h] = ST_ALLOC;
            if (h == m_switch) sw = 1'b1;
            else begin
              e = '0;
              e.kind = 1'b1;
              e.out_slot = 5'(h);
              e.out_owner = m_owner[h];
              e.out_tag = m_tag[h];
              pending_results.push_back(e);
            end
            m_head = m_link[h];
          end
          if (m_head > TIMERS) m_head = NIL;
          refresh_due();
        end
        r.switch_request = sw;
      end
      CMD_ALLOC: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (m_status[i] == ST_FREE) begin
            m_status[i] = ST_ALLOC;
            m_ac[i] = 1'b0;
            r.out_slot = 5'(i);
            r.ok = 1'b1;
            break;
          end
        end
      end
      CMD_FREE: begin
        void'(disarm(c.slot));
        m_status[c.slot] = ST_FREE;
      end
      CMD_INIT: begin
        m_owner[c.slot] = c.owner;
        m_tag[c.slot] = c.tag;
        m_ac[c.slot] = c.auto_cancel;
        m_inited[c.slot] = 1'b1;
      end
      CMD_SETTIME: begin
        d = m_count + c.duration;
        if (d < m_count) d = NONE_DUE;
        void'(disarm(c.slot));
        m_due[c.slot] = d;
        m_status[c.slot] = ST_ARMED;
        link_in(c.slot);
      end
      CMD_CANCEL: r.ok = disarm(c.slot);
      CMD_CANCELALL: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (m_status[i] != ST_FREE && m_ac[i] && m_owner[i] == c.owner) begin
            void'(disarm(i));
            m_status[i] = ST_FREE;
          end
        end
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endfunction

  task automatic send_item(cmd_t c);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
      @(posedge clk);
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    predict_pool(c);
    cmd_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_switch_slot(logic [5:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_SWITCH_SLOT[0], 2'b00};
    pwdata <= {26'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    m_switch = v;
  endtask

  function automatic cmd_t make_cmd(logic [2:0] op, int s, logic [7:0] own,
                                    logic [31:0] tg, logic ac, logic [31:0] dur);
    cmd_t c;
    c.command = op;
    c.slot = 5'(s);
    c.owner = own;
    c.tag = tg;
    c.auto_cancel = ac;
    c.duration = dur;
    return c;
  endfunction

  // random item, mostly coherent: allocate, init, arm and tick, with some free, cancel, cancel-all and undefined items
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   s;
    int   pick;
    c = '0;
    c.owner = 8'($urandom);
    c.tag = $urandom;
    c.auto_cancel = 1'($urandom);
    c.duration = $urandom;
    s = $urandom_range(TIMERS - 1, 0);
    pick = $urandom_range(99, 0);
    if (pick < 30) c.command = CMD_TICK;
    else if (pick < 42) c.command = CMD_ALLOC;
    else if (pick < 50) c.command = CMD_FREE;
    else if (pick < 62) c.command = CMD_INIT;
    else if (pick < 82) c.command = CMD_SETTIME;
    else if (pick < 90) c.command = CMD_CANCEL;
    else if (pick < 96) c.command = CMD_CANCELALL;
    else c.command = CMD_UNDEF;
    // no expiry may report an owner or tag that was never written
    if (c.command == CMD_SETTIME && !m_inited[s]) c.command = CMD_INIT;
    c.slot = 5'(s);
    c.owner[7:2] = 6'd0;
    if ($urandom_range(3, 0) != 0)
      c.duration = (m_count > 32'hFFFF_FF00 && $urandom_range(1, 0)) ?
                   $urandom : $urandom_range(12, 0);
    return c;
  endfunction

  task automatic test_reset_and_init();
    for (int i = 0; i < TIMERS; i++)
      send_item(make_cmd(CMD_INIT, i, {6'd0, i[1:0]}, 32'h8000_0000 ^ i, i[0], 32'd0));
  endtask

  task automatic test_directed();
    send_item(make_cmd(CMD_ALLOC, 0, 8'd0, 32'd0, 1'b0, 32'd0));
    send_item(make_cmd(CMD_INIT, 0, 8'hFF, 32'h7FFF_FFFF, 1'b1, 32'd0));
    send_item(make_cmd(CMD_SETTIME, 0, 8'd0, 32'd0, 1'b0, 32'd2));
    send_item(make_cmd(CMD_SETTIME, 1, 8'd0, 32'd0, 1'b0, 32'd2));
    send_item(make_cmd(CMD_SETTIME, 31, 8'd0, 32'd0, 1'b0, 32'd0));
    send_item(make_cmd(CMD_SETTIME, 2, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    send_item(make_cmd(CMD_SETTIME, 1, 8'd0, 32'd0, 1'b0, 32'd1));
    send_item(make_cmd(CMD_TICK, 0, 8'd0, 32'd0, 1'b0, 32'd0));
    send_item(make_cmd(CMD_TICK, 0, 8'd0, 32'd0, 1'b0, 32'd0));
    send_item(make_cmd(CMD_CANCEL, 2, 8'd0, 32'd0, 1'b0, 32'd0));
    send_item(make_cmd(CMD_CANCEL, 2, 8'd0, 32'd0, 1'b0, 32'd0));
    send_item(make_cmd(CMD_SETTIME, 3, 8'd0, 32'd0, 1'b0, 32'd4));
    send_item(make_cmd(CMD_FREE, 3, 8'd0, 32'd0, 1'b0, 32'd0));
    send_item(make_cmd(CMD_SETTIME, 5, 8'd0, 32'd0, 1'b0, 32'd9));
    send_item(make_cmd(CMD_CANCELALL, 0, 8'd1, 32'd0, 1'b0, 32'd0));
    send_item(make_cmd(CMD_UNDEF, 31, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    for (int i = 0; i < TIMERS + 1; i++)
      send_item(make_cmd(CMD_ALLOC, 0, 8'd0, 32'd0, 1'b0, 32'd0));
    drain();
  endtask

  task automatic test_switch_slot();
    write_switch_slot(6'd4);
    send_item(make_cmd(CMD_SETTIME, 4, 8'd0, 32'd0, 1'b0, 32'd1));
    send_item(make_cmd(CMD_SETTIME, 6, 8'd0, 32'd0, 1'b0, 32'd1));
    send_item(make_cmd(CMD_TICK, 0, 8'd0, 32'd0, 1'b0, 32'd0));
    drain();
    write_switch_slot(6'd0);
    send_item(make_cmd(CMD_SETTIME, 0, 8'd0, 32'd0, 1'b0, 32'd1));
    send_item(make_cmd(CMD_TICK, 0, 8'd0, 32'd0, 1'b0, 32'd0));
    drain();
    write_switch_slot(6'd31);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) send_item(random_cmd());
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 8; i++)
      send_item(make_cmd(CMD_SETTIME, i, 8'd0, 32'd0, 1'b0, 32'd1));
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        send_item(make_cmd(CMD_TICK, 0, 8'd0, 32'd0, 1'b0, 32'd0));
        for (int i = 0; i < 6; i++)
          send_item(make_cmd(CMD_ALLOC, 0, 8'd0, 32'd0, 1'b0, 32'd0));
      end
    join
    drain();
  endtask

  task automatic test_count_limit();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // arm far-off and overflowing due times near the top of the counter
    send_item(make_cmd(CMD_SETTIME, 7, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFF0));
    send_item(make_cmd(CMD_SETTIME, 8, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    for (int i = 0; i < 6; i++)
      send_item(make_cmd(CMD_TICK, 0, 8'd0, 32'd0, 1'b0, 32'd0));
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= !recv_hold &&
                   !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $realtime, res);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (res !== e) begin
          $display("%0t result mismatch: expected %p actual %p", $realtime, e, res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cmd_valid <= 1'b0;
    cmd <= '0;
    pool_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_and_init();
    test_directed();
    test_switch_slot();
    test_random(20, 28, 52);
    write_switch_slot(6'd32);
    test_random(20, 52, 28);
    test_backpressure();
    test_random(20, 0, 0);
    test_count_limit();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### software_timer_pool.f
+incdir+sv
sv/stp_pkg.sv
sv/stp_ram.sv
sv/stp_seq.sv
sv/software_timer_pool.sv
sv/stp_checker.sv
verif/software_timer_pool_tb.sv
